FILE: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, operation and status codes and the cell command type for
// the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              rd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

FILE: rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. Loads the new word, takes its lower neighbor on insert,
// takes its upper neighbor on remove, otherwise holds.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cmd_t              cmd_i,
  input  logic [DATA_W-1:0] lower_i,
  input  logic [DATA_W-1:0] upper_i,
  output logic [DATA_W-1:0] entry_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [CMP_W-1:0]  idx_x, pos_x;

  assign idx_x = CMP_W'(idx_i);
  assign pos_x = CMP_W'(cmd_i.pos);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_x == pos_x) begin
        entry_d = cmd_i.data;
      end else if (idx_x > pos_x) begin
        entry_d = lower_i;
      end
    end else if (cmd_i.rem) begin
      if (idx_x >= pos_x) begin
        entry_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (cmd_i.rd && (idx_x == pos_x)) ? entry_q : '0;

endmodule

FILE: rtl/positional_array_list_top.sv
// ----------------------------------------------------------------------------
// positional_array_list_top
// Ordered list of record words with positional insert, remove and read,
// held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | operation, position, entry_data
// out     | output    | out_valid_o / out_stall_i | status, read_data, entry_count,
//         |           |                           | is_full, is_empty
//
// One item per cycle unless stalled; its result appears in the cycle after
// acceptance, from the output register. All cells shift in the acceptance cycle.
// Reset clears the count and the output valid; cell contents stay undefined.
// Input stalls only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module positional_array_list_top import pal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] entry_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [POS_W-1:0]  entry_count_o,
  output logic              is_full_o,
  output logic              is_empty_o
);

  logic              acc;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic [ST_W-1:0]   status_q, status_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [CNT_W-1:0]  ocount_q;
  logic              full_q, empty_q;
  logic              ok;
  logic [CMP_W-1:0]  pos_x, cnt_x;
  cmd_t              cmd;

  logic [DATA_W-1:0] entry [CAPACITY];
  logic [DATA_W-1:0] rd    [CAPACITY];

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign pos_x      = CMP_W'(position_i);
  assign cnt_x      = CMP_W'(count_q);

  always_comb begin
    status_d = ST_OK;
    case (operation_i)
      OP_INSERT: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_d = ST_BADPOS;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_d = ST_BADPOS;
        end
      end
      default: status_d = ST_BADPOS;
    endcase
  end

  assign ok       = (status_d == ST_OK);
  assign cmd.ins  = acc && ok && (operation_i == OP_INSERT);
  assign cmd.rem  = acc && ok && (operation_i == OP_REMOVE);
  assign cmd.rd   = ok && (operation_i == OP_READ);
  assign cmd.pos  = position_i;
  assign cmd.data = entry_data_i;

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (i == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = entry[i+1];
    end
    pal_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[i]),
      .rd_o    (rd[i])
    );
  end

  always_comb begin
    rdata_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rdata_d = rdata_d | rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      ocount_q <= count_d;
      full_q   <= (count_d == CNT_W'(CAPACITY));
      empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_data_o   = rdata_q;
  assign entry_count_o = POS_W'(ocount_q);
  assign is_full_o     = full_q;
  assign is_empty_o    = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_data_o == '0)
    else $error("read data nonzero on error");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("full and empty together");

endmodule

FILE: tb/positional_array_list_top_tb.sv
// ----------------------------------------------------------------------------
// positional_array_list_top_tb
// Drives positional insert, remove and read items into the list, predicts
// each result from a shadow copy of the list, and compares every result
// field. Runs with no idling, a mostly idle sender, a mostly stalling
// receiver, and light idling on both sides.
// ----------------------------------------------------------------------------
module positional_array_list_top_tb;
  import pal_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] read_data;
    logic [POS_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
  } list_result_t;

  class list_scoreboard;
    logic [DATA_W-1:0] cells [CAPACITY];
    int unsigned       count;
    list_result_t      expected_q [$];
    int unsigned       errors;
    int unsigned       n_results;
    int unsigned       n_ok;
    int unsigned       n_full;
    int unsigned       n_empty;
    int unsigned       n_badpos;
    int unsigned       peak;

    function new();
      count = 0;
      errors = 0;
      n_results = 0;
      n_ok = 0;
      n_full = 0;
      n_empty = 0;
      n_badpos = 0;
      peak = 0;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [DATA_W-1:0] data);
      list_result_t r;
      int unsigned  i;
      r.status    = ST_OK;
      r.read_data = '0;
      case (op)
        OP_INSERT: begin
          if (count >= CAPACITY) r.status = ST_FULL;
          else if (pos > count) r.status = ST_BADPOS;
          else begin
            for (i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos[IDX_W-1:0]] = data;
            count++;
          end
        end
        OP_REMOVE: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (pos >= count) r.status = ST_BADPOS;
          else begin
            for (i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        OP_READ: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (pos >= count) r.status = ST_BADPOS;
          else r.read_data = cells[pos[IDX_W-1:0]];
        end
        default: r.status = ST_BADPOS;
      endcase
      r.entry_count = count[POS_W-1:0];
      r.is_full     = (count == CAPACITY);
      r.is_empty    = (count == 0);
      if (count > peak) peak = count;
      case (r.status)
        ST_OK:    n_ok++;
        ST_FULL:  n_full++;
        ST_EMPTY: n_empty++;
        default:  n_badpos++;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(list_result_t got);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report("result with no pending item");
        return;
      end
      e = expected_q.pop_front();
      n_results++;
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.read_data !== e.read_data)
        report($sformatf("read_data %h, expected %h", got.read_data, e.read_data));
      if (got.entry_count !== e.entry_count)
        report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                         e.entry_count));
      if (got.is_full !== e.is_full)
        report($sformatf("is_full %b, expected %b", got.is_full, e.is_full));
      if (got.is_empty !== e.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, e.is_empty));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   operation_i;
  logic [POS_W-1:0]  position_i;
  logic [DATA_W-1:0] entry_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ST_W-1:0]   status_o;
  logic [DATA_W-1:0] read_data_o;
  logic [POS_W-1:0]  entry_count_o;
  logic              is_full_o;
  logic              is_empty_o;

  list_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;

  positional_array_list_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .entry_data_i  (entry_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status      = status_o;
      got.read_data   = read_data_o;
      got.entry_count = entry_count_o;
      got.is_full     = is_full_o;
      got.is_empty    = is_empty_o;
      sb.check_result(got);
    end
  end

  task send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    entry_data_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, pos, data);
  endtask

  // mode 0 grows the list, 1 mixes, 2 shrinks it
  task send_random(int mode);
    int unsigned       r;
    int unsigned       w_ins;
    int unsigned       w_rem;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    w_ins = (mode == 0) ? 70 : (mode == 1) ? 35 : 10;
    w_rem = (mode == 0) ? 10 : (mode == 1) ? 30 : 70;
    r = $urandom_range(99);
    if (r < w_ins) op = OP_INSERT;
    else if (r < w_ins + w_rem) op = OP_REMOVE;
    else if (r < 98) op = OP_READ;
    else op = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 8) pos = POS_W'($urandom_range(CAPACITY));
    else if (r < 10) pos = POS_W'($urandom_range(127));
    else if (op == OP_INSERT) begin
      if (r < 20) pos = POS_W'(sb.count);
      else if (r < 25) pos = '0;
      else pos = POS_W'($urandom_range(sb.count));
    end else begin
      if (sb.count == 0) pos = '0;
      else if (r < 20) pos = POS_W'(sb.count - 1);
      else if (r < 25) pos = '0;
      else pos = POS_W'($urandom_range(sb.count - 1));
    end
    r = $urandom_range(99);
    if (r < 10) data = '0;
    else if (r < 20) data = '1;
    else data = $urandom;
    send_item(op, pos, data);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int k;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_INSERT;
    position_i   <= '0;
    entry_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_READ,   POS_W'(0), '0);
    send_item(OP_REMOVE, POS_W'(0), '0);
    send_item(OP_INSERT, POS_W'(1), 32'h1234_5678);
    send_item(OP_INSERT, POS_W'(0), 32'h0000_0000);
    send_item(OP_INSERT, POS_W'(1), 32'hFFFF_FFFF);
    send_item(OP_INSERT, POS_W'(1), 32'hA5A5_A5A5);
    send_item(OP_INSERT, POS_W'(0), 32'h5A5A_5A5A);
    for (k = 0; k < 5; k++) send_item(OP_READ, POS_W'(k), '0);
    send_item(OP_REMOVE, POS_W'(4), '0);
    send_item(OP_INSERT, POS_W'(CAPACITY), 32'hDEAD_BEEF);
    send_item(OP_READ,   POS_W'(127), '0);
    send_item(OP_UNUSED, POS_W'(0), '1);
    send_item(OP_UNUSED, POS_W'(127), '0);
    send_item(OP_REMOVE, POS_W'(1), '0);
    send_item(OP_REMOVE, POS_W'(2), '0);
    send_item(OP_REMOVE, POS_W'(0), '0);
    send_item(OP_READ,   POS_W'(0), '0);
    send_item(OP_REMOVE, POS_W'(0), '0);
    send_item(OP_READ,   POS_W'(0), '0);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      for (k = 0; k < 480; k++) send_random((k / 120) % 3);
      wait_drained();
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report("items left without a result");
    $display("checked %0d results: %0d ok, %0d full, %0d empty, %0d bad position",
             sb.n_results, sb.n_ok, sb.n_full, sb.n_empty, sb.n_badpos);
    $display("list reached %0d of %0d entries; %0d mismatches",
             sb.peak, CAPACITY, sb.errors);
    if (sb.errors == 0) begin
      $display("positional_array_list_top_tb: PASS");
    end else begin
      $display("positional_array_list_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("positional_array_list_top_tb: FAIL");
    $finish;
  end

endmodule
